### hdl/plc_pkg.sv
// Package for the pump level controller: constants, register indexes
// and the duty table lookup. No dependencies.
package plc_pkg;

   localparam int NUM_LEVELS = 10;

   localparam int TEMP_W  = 21;
   localparam int CRIT_W  = 13;
   localparam int LEVEL_W = 4;
   localparam int DUTY_W  = 8;
   localparam int CNT_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int TBL_LO_W   = 64;
   localparam int TBL_HI_W   = 16;
   // compare width, one bit above the sample so margin sums cannot wrap
   localparam int CMP_W = TEMP_W + 1;

   localparam logic signed [TEMP_W-1:0] LIMIT_POS = TEMP_W'(1000000);
   localparam logic signed [TEMP_W-1:0] LIMIT_NEG = -TEMP_W'(1000000);
   localparam logic signed [TEMP_W-1:0] SUBST_TEMP = TEMP_W'(9999);
   localparam logic signed [TEMP_W-1:0] LAST_TEMP_RST = TEMP_W'(2000);
   localparam logic signed [CMP_W-1:0]  MARGIN = CMP_W'(20);
   localparam logic [CNT_W-1:0]   EVAL_LAST = CNT_W'(5);

   localparam logic [CRIT_W-1:0]   CRIT_RST   = CRIT_W'(2000);
   localparam logic [TBL_LO_W-1:0] TBL_LO_RST = 64'h3232_3232_3232_3232;
   localparam logic [TBL_HI_W-1:0] TBL_HI_RST = 16'h3232;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(NUM_LEVELS - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CRITICAL_TEMP   = 2'd0,
      CSR_DUTY_TABLE_LOW  = 2'd1,
      CSR_DUTY_TABLE_HIGH = 2'd2
   } csr_index_type;

   // duty byte of a level; levels past the table read as zero
   function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] lv,
                                                  input logic [TBL_LO_W-1:0] lo,
                                                  input logic [TBL_HI_W-1:0] hi);
      logic [DUTY_W-1:0] d;
      if (lv < LEVEL_W'(8)) begin
         d = lo[lv[2:0]*DUTY_W +: DUTY_W];
      end else if (lv < LEVEL_W'(10)) begin
         d = hi[lv[0]*DUTY_W +: DUTY_W];
      end else begin
         d = '0;
      end
      return d;
   endfunction

endpackage

### hdl/pump_level_controller_core.sv
// Pump level controller core: input stage, level decision, result register.
// Depends on plc_pkg.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   req     | req_valid/ready, req_temp_sample   | in
//   rsp     | rsp_valid/ready, pwm_duty, level,  | out
//           | evaluated, shown_temp              |
//   csr     | csr_valid/ready, index, data       | in
//
// One beat per cycle sustained while rsp is not stalled; a sample reaches rsp
// through the input register, then the result register. The level decision sits
// between those registers and updates the controller state as the result
// is loaded, so the next sample sees it at once. Synchronous reset restores
// the state and register defaults. A stalled rsp holds both stages; req_ready
// drops only when both are full and rsp is not taken. csr is always ready.
module pump_level_controller_core (
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   output logic req_ready,
   input  logic signed [plc_pkg::TEMP_W-1:0] req_temp_sample,

   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [plc_pkg::DUTY_W-1:0]         rsp_pwm_duty,
   output logic [plc_pkg::LEVEL_W-1:0]        rsp_drive_level,
   output logic                               rsp_evaluated,
   output logic signed [plc_pkg::TEMP_W-1:0]  rsp_shown_temp,

   input  logic csr_valid,
   output logic csr_ready,
   input  logic [plc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [plc_pkg::CSR_DATA_W-1:0] csr_data
);

   // configuration
   logic [plc_pkg::CRIT_W-1:0]   crit_ff;
   logic [plc_pkg::TBL_LO_W-1:0] tbl_lo_ff;
   logic [plc_pkg::TBL_HI_W-1:0] tbl_hi_ff;

   // controller state
   logic [plc_pkg::CNT_W-1:0]          count_ff, count_in;
   logic signed [plc_pkg::TEMP_W-1:0]  last_ff, last_in;
   logic                               above_ff, above_in;
   logic [plc_pkg::LEVEL_W-1:0]        level_ff, level_in;

   // input stage
   logic                               s1_valid_ff, s1_valid_in;
   logic signed [plc_pkg::TEMP_W-1:0]  s1_temp_ff;

   // result stage
   logic                               out_valid_ff, out_valid_in;
   logic [plc_pkg::DUTY_W-1:0]         out_duty_ff;
   logic [plc_pkg::LEVEL_W-1:0]        out_level_ff;
   logic                               out_eval_ff;
   logic signed [plc_pkg::TEMP_W-1:0]  out_temp_ff;

   logic advance;   // input stage moves into the result register
   logic take_req;
   logic signed [plc_pkg::TEMP_W-1:0] cur;
   logic signed [plc_pkg::CMP_W-1:0]  cur_x, prev_x, crit_x;
   logic eval;

   assign csr_ready = 1'b1;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   assign s1_valid_in  = take_req || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // decision logic
   always_comb begin
      // out-of-range samples show and compare as 99.99 degrees
      if (s1_temp_ff > plc_pkg::LIMIT_POS || s1_temp_ff < plc_pkg::LIMIT_NEG) begin
         cur = plc_pkg::SUBST_TEMP;
      end else begin
         cur = s1_temp_ff;
      end
      cur_x  = plc_pkg::CMP_W'(cur);
      prev_x = plc_pkg::CMP_W'(last_ff);
      crit_x = signed'({{(plc_pkg::CMP_W-plc_pkg::CRIT_W){1'b0}}, crit_ff});

      eval     = (count_ff == plc_pkg::EVAL_LAST);
      count_in = eval ? '0 : count_ff + plc_pkg::CNT_W'(1);
      level_in = level_ff;
      above_in = above_ff;
      last_in  = cur;

      if (eval) begin
         if (cur_x > crit_x) begin
            // step up unless falling fast; top level holds
            if (cur_x >= prev_x - plc_pkg::MARGIN && level_ff != plc_pkg::LEVEL_TOP) begin
               level_in = level_ff + plc_pkg::LEVEL_W'(1);
            end
            above_in = 1'b1;
         end else begin
            if (above_ff) begin
               level_in = level_ff >> 1;   // just dropped below: halve
            end else if (cur_x <= prev_x + plc_pkg::MARGIN && level_ff != '0) begin
               level_in = level_ff - plc_pkg::LEVEL_W'(1);
            end
            above_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crit_ff   <= plc_pkg::CRIT_RST;
         tbl_lo_ff <= plc_pkg::TBL_LO_RST;
         tbl_hi_ff <= plc_pkg::TBL_HI_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            plc_pkg::CSR_CRITICAL_TEMP:   crit_ff   <= csr_data[plc_pkg::CRIT_W-1:0];
            plc_pkg::CSR_DUTY_TABLE_LOW:  tbl_lo_ff <= csr_data[plc_pkg::TBL_LO_W-1:0];
            plc_pkg::CSR_DUTY_TABLE_HIGH: tbl_hi_ff <= csr_data[plc_pkg::TBL_HI_W-1:0];
            default: ;   // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_ff      <= plc_pkg::LAST_TEMP_RST;
         above_ff     <= 1'b0;
         level_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            count_ff <= count_in;
            last_ff  <= last_in;
            above_ff <= above_in;
            level_ff <= level_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_temp_ff <= req_temp_sample;
      end
      if (advance) begin
         out_duty_ff  <= plc_pkg::duty_of(level_in, tbl_lo_ff, tbl_hi_ff);
         out_level_ff <= level_in;
         out_eval_ff  <= eval;
         out_temp_ff  <= cur;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pwm_duty    = out_duty_ff;
   assign rsp_drive_level = out_level_ff;
   assign rsp_evaluated   = out_eval_ff;
   assign rsp_shown_temp  = out_temp_ff;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for pump_level_controller_core: random and directed temperature beats
// with a cycle-free predictor of the level logic. Depends on plc_pkg and the core.
module tb;

   localparam int SAMPLE_LIMIT   = 1000000;  // +/-10000.00 degrees
   localparam int SUBST_CENTI    = 9999;     // shown for out-of-range samples
   localparam int MARGIN_CENTI   = 20;       // 0.20 degree hysteresis
   localparam int EVAL_PERIOD    = 6;        // every sixth sample is evaluated
   localparam int MAX_GAP        = 16;
   localparam int WATCHDOG_LIMIT = 1000;

   // decodes to nothing
   localparam logic [plc_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   localparam logic [plc_pkg::CRIT_W-1:0]   CRIT_DEFAULT    = 13'd2000;
   localparam logic [plc_pkg::TBL_LO_W-1:0] DUTY_LO_DEFAULT = 64'h3232_3232_3232_3232;
   localparam logic [plc_pkg::TBL_HI_W-1:0] DUTY_HI_DEFAULT = 16'h3232;

   typedef struct packed {
      logic [plc_pkg::DUTY_W-1:0]         duty;
      logic [plc_pkg::LEVEL_W-1:0]        level;
      logic                               evaluated;
      logic signed [plc_pkg::TEMP_W-1:0]  shown;
   } level_report_type;

   logic clock;
   logic reset;

   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [plc_pkg::TEMP_W-1:0]    req_temp_sample;

   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [plc_pkg::DUTY_W-1:0]           rsp_pwm_duty;
   logic [plc_pkg::LEVEL_W-1:0]          rsp_drive_level;
   logic                                 rsp_evaluated;
   logic signed [plc_pkg::TEMP_W-1:0]    rsp_shown_temp;

   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [plc_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [plc_pkg::CSR_DATA_W-1:0]       csr_data;

   // controller state as the predictor sees it
   logic [plc_pkg::CRIT_W-1:0]   crit_setting = CRIT_DEFAULT;
   logic [plc_pkg::TBL_LO_W-1:0] duty_lo      = DUTY_LO_DEFAULT;
   logic [plc_pkg::TBL_HI_W-1:0] duty_hi      = DUTY_HI_DEFAULT;
   int                  sample_phase = 0;
   int                  prior_temp   = 2000;
   bit                  hot_flag     = 1'b0;
   int                  drive_lvl    = 0;

   level_report_type predicted_levels[$];

   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   bit  pace_gaps      = 1'b1;   // both sides idle at random when set

   // random walk used for well-formed temperature traces
   int  walk_temp;
   int  walk_step_lo;
   int  walk_step_hi;
   int  walk_left = 0;

   pump_level_controller_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_temp_sample (req_temp_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pwm_duty    (rsp_pwm_duty),
      .rsp_drive_level (rsp_drive_level),
      .rsp_evaluated   (rsp_evaluated),
      .rsp_shown_temp  (rsp_shown_temp),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Level logic for one accepted sample; updates the predictor state.
   function automatic level_report_type advance_level_logic(
         input logic signed [plc_pkg::TEMP_W-1:0] sample);
      level_report_type r;
      int t;
      int crit;
      int lv;
      t    = sample;
      crit = int'(crit_setting);
      r.evaluated = 1'b0;
      if (t > SAMPLE_LIMIT || t < -SAMPLE_LIMIT) begin
         t = SUBST_CENTI;
      end
      sample_phase = sample_phase + 1;
      if (sample_phase >= EVAL_PERIOD) begin
         sample_phase = 0;
         r.evaluated  = 1'b1;
         lv = drive_lvl;
         if (t > crit) begin
            // hot: step up unless it is already cooling past the margin
            if (t >= prior_temp - MARGIN_CENTI) begin
               lv = lv + 1;
            end
            hot_flag = 1'b1;
         end else begin
            // just fell back below the critical point: halve
            if (hot_flag) begin
               lv = lv / 2;
            end else if (t <= prior_temp + MARGIN_CENTI) begin
               lv = lv - 1;
            end
            hot_flag = 1'b0;
         end
         // a level outside the table is dropped
         if (lv >= 0 && lv < plc_pkg::NUM_LEVELS) begin
            drive_lvl = lv;
         end
      end
      prior_temp = t;
      r.level = plc_pkg::LEVEL_W'(drive_lvl);
      r.duty  = (drive_lvl < 8) ? duty_lo[8*drive_lvl +: plc_pkg::DUTY_W]
                                : duty_hi[8*(drive_lvl-8) +: plc_pkg::DUTY_W];
      r.shown = plc_pkg::TEMP_W'(t);
      return r;
   endfunction

   // One sample beat; starts and ends just after a falling edge.
   task automatic send_sample(input logic signed [plc_pkg::TEMP_W-1:0] t);
      int gap;
      gap = pace_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_temp_sample = t;
      do @(posedge clock); while (!req_ready);
      predicted_levels.push_back(advance_level_logic(t));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_for_drain();
      while (predicted_levels.size() != 0) @(negedge clock);
   endtask

   // Register write, only once the core has handed back every result.
   task automatic write_register(input logic [plc_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [plc_pkg::CSR_DATA_W-1:0] value);
      wait_for_drain();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         plc_pkg::CSR_CRITICAL_TEMP:   crit_setting = value[plc_pkg::CRIT_W-1:0];
         plc_pkg::CSR_DUTY_TABLE_LOW:  duty_lo      = value[plc_pkg::TBL_LO_W-1:0];
         plc_pkg::CSR_DUTY_TABLE_HIGH: duty_hi      = value[plc_pkg::TBL_HI_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [plc_pkg::CSR_DATA_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   task automatic random_settings();
      logic [plc_pkg::CSR_DATA_W-1:0] crit_word;
      crit_word = random_word();
      // mostly inside 0..50 degrees, sometimes above the nominal range
      if ($urandom_range(0, 3) != 0) begin
         crit_word[plc_pkg::CRIT_W-1:0] = plc_pkg::CRIT_W'($urandom_range(0, 5000));
      end
      write_register(plc_pkg::CSR_CRITICAL_TEMP, crit_word);
      write_register(plc_pkg::CSR_DUTY_TABLE_LOW, random_word());
      write_register(plc_pkg::CSR_DUTY_TABLE_HIGH, random_word());
   endtask

   // Mostly a temperature trace that drifts around the critical point in
   // segments (heating, cooling, hovering); the rest is noise.
   task automatic run_traffic(input int count);
      int crit;
      int v;
      crit      = int'(crit_setting);
      walk_temp = crit + $urandom_range(0, 400) - 200;
      walk_left = 0;
      for (int i = 0; i < count; i++) begin
         if (walk_left == 0) begin
            walk_left = $urandom_range(30, 150);
            case ($urandom_range(0, 2))
               0: begin walk_step_lo = 0;   walk_step_hi = 12; end
               1: begin walk_step_lo = -12; walk_step_hi = 0;  end
               default: begin walk_step_lo = -30; walk_step_hi = 30; end
            endcase
         end
         walk_left = walk_left - 1;
         walk_temp = walk_temp + walk_step_lo
                     + int'($urandom_range(0, walk_step_hi - walk_step_lo));
         // pinned at the rails the trace stays flat, which keeps pushing the
         // level against the top and the bottom of the table
         if (walk_temp > crit + 3000) walk_temp = crit + 3000;
         if (walk_temp < crit - 3000) walk_temp = crit - 3000;
         v = walk_temp;
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: v = int'(plc_pkg::TEMP_W'($urandom));
               1: v = SAMPLE_LIMIT + $urandom_range(0, 2);
               2: v = -SAMPLE_LIMIT - $urandom_range(0, 2);
               default: v = ($urandom & 1) ? -(1 << (plc_pkg::TEMP_W-1))
                                           : (1 << (plc_pkg::TEMP_W-1)) - 1;
            endcase
            if (v >= (1 << (plc_pkg::TEMP_W-1))) v = v - (1 << plc_pkg::TEMP_W);
         end
         send_sample(plc_pkg::TEMP_W'(v));
      end
   endtask

   // Defaults after reset, range limits of the sample, each branch of the
   // evaluation and the margin edges.
   task automatic test_directed_extremes();
      int seq [24];
      seq = '{0, -1, 1000000, -1000000, 1000001, 1048575,      // out of range -> 99.99, step up
              -1048576, -1000001, 2000, 2021, 2500, 1500,      // fall below critical: halve
              1000, 1200, 1300, 1400, 1980, 2000,              // at critical, step below zero dropped
              2500, 2600, 2700, 2800, 3000, 2979};             // hot but falling past margin: hold
      pace_gaps = 1'b0;
      foreach (seq[i]) send_sample(plc_pkg::TEMP_W'(seq[i]));
      pace_gaps = 1'b1;
      foreach (seq[i]) send_sample(plc_pkg::TEMP_W'(seq[i]));
   endtask

   // Register writes at the extremes and back, traffic under each setting.
   task automatic test_register_settings();
      write_register(plc_pkg::CSR_CRITICAL_TEMP, random_word() & ~64'h1FFF);
      write_register(plc_pkg::CSR_DUTY_TABLE_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      write_register(plc_pkg::CSR_DUTY_TABLE_HIGH, 64'h0000_0000_0000_FFFF);
      run_traffic(50);

      // critical point above 50.00 degrees is taken as written
      write_register(plc_pkg::CSR_CRITICAL_TEMP, {random_word() | 64'h1FFF});
      write_register(plc_pkg::CSR_DUTY_TABLE_LOW, 64'h0);
      write_register(plc_pkg::CSR_DUTY_TABLE_HIGH, random_word() & ~64'hFFFF);
      run_traffic(50);

      write_register(plc_pkg::CSR_CRITICAL_TEMP, 64'd5000);
      write_register(plc_pkg::CSR_DUTY_TABLE_LOW, 64'h0706_0504_0302_0100);
      write_register(plc_pkg::CSR_DUTY_TABLE_HIGH, 64'h0908);
      run_traffic(50);

      // the spare index must leave every register alone
      write_register(CSR_SPARE_INDEX, random_word());
      run_traffic(40);

      random_settings();
      run_traffic(50);

      write_register(plc_pkg::CSR_CRITICAL_TEMP, 64'(CRIT_DEFAULT));
      write_register(plc_pkg::CSR_DUTY_TABLE_LOW, 64'(DUTY_LO_DEFAULT));
      write_register(plc_pkg::CSR_DUTY_TABLE_HIGH, 64'(DUTY_HI_DEFAULT));
      run_traffic(40);
   endtask

   // Long traces in chunks with and without idling, new settings between some.
   task automatic test_random_traffic();
      for (int chunk = 0; chunk < 7; chunk++) begin
         pace_gaps = ($urandom_range(0, 2) != 0);
         if (chunk % 3 == 2) begin
            random_settings();
         end
         run_traffic(30);
         // sender holds off until the core has drained
         wait_for_drain();
         run_traffic(30);
      end
      pace_gaps = 1'b1;
   endtask

   // Result side: random stall per beat, none while pace_gaps is clear.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = pace_gaps ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Each result beat against the oldest prediction.
   always @(posedge clock) begin
      level_report_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_levels.size() == 0) begin
            $display("%0t: result beat with nothing expected (duty %0d level %0d eval %0d temp %0d)",
                     $time, rsp_pwm_duty, rsp_drive_level, rsp_evaluated, rsp_shown_temp);
            mismatch_count++;
         end else begin
            exp_r = predicted_levels.pop_front();
            if (rsp_pwm_duty !== exp_r.duty) begin
               $display("%0t: pwm_duty expected %0d actual %0d",
                        $time, exp_r.duty, rsp_pwm_duty);
               mismatch_count++;
            end
            if (rsp_drive_level !== exp_r.level) begin
               $display("%0t: drive_level expected %0d actual %0d",
                        $time, exp_r.level, rsp_drive_level);
               mismatch_count++;
            end
            if (rsp_evaluated !== exp_r.evaluated) begin
               $display("%0t: evaluated expected %0d actual %0d",
                        $time, exp_r.evaluated, rsp_evaluated);
               mismatch_count++;
            end
            if (rsp_shown_temp !== exp_r.shown) begin
               $display("%0t: shown_temp expected %0d actual %0d",
                        $time, exp_r.shown, rsp_shown_temp);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: too long without any accepted beat ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_temp_sample = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_extremes();
      test_register_settings();
      test_random_traffic();

      wait_for_drain();
      // keep running so a stray extra beat would still be caught
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/plc_pkg.sv
hdl/pump_level_controller_core.sv
dv/tb.sv
